[sv/sff_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, register codes and payload types of the strided FIR filter.
// Used by every module of the block; depends on nothing else.
package sff_pkg;

    // Kernel and stream geometry.
    localparam int MAX_TAPS     = 5;
    localparam int MAX_CHANNELS = 4;
    localparam int COEF_REGS    = 5;
    localparam int LAG_MAX      = (MAX_TAPS / 2) * MAX_CHANNELS;
    localparam int WIN_DEPTH    = 2 * LAG_MAX + 1;

    // Field widths.
    localparam int SAMPLE_W  = 8;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 3;
    localparam int REG_IDX_W = 3;
    localparam int FRAC_BITS = 12;
    localparam int PIXEL_MAX = 255;

    // Derived internal widths.
    localparam int CH_W       = $clog2(MAX_CHANNELS + 1);
    localparam int TAP_W      = $clog2(MAX_TAPS + 1);
    localparam int D_W        = (LAG_MAX > 0) ? $clog2(LAG_MAX + 1) : 1;
    localparam int K_W        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int KS_W       = K_W + 1;
    localparam int OFS_W      = D_W + 1;
    localparam int PROD_W     = SAMPLE_W + 1 + COEF_W;
    localparam int SUM_W      = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int COEF_IDX_W = (COEF_REGS > 1) ? $clog2(COEF_REGS) : 1;

    // Job queue between the front and the back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_TAP_COUNT     = 3'd1,
        REG_COEF_0        = 3'd2,
        REG_COEF_1        = 3'd3,
        REG_COEF_2        = 3'd4,
        REG_COEF_3        = 3'd5,
        REG_COEF_4        = 3'd6
    } reg_idx_t;

    // One input request.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                final_req;
    } sff_in_t;

    // One result request.
    typedef struct packed {
        logic [SAMPLE_W-1:0] pixel;
        logic                end_of_run;
    } sff_out_t;

    // Effective (clamped) configuration seen by the datapath.
    typedef struct packed {
        logic [CH_W-1:0]                    channels;
        logic [TAP_W-1:0]                   taps;
        logic [MAX_TAPS-1:0][COEF_W-1:0]    coef;
    } sff_cfg_t;

    // Work handed from the front to the back: a window snapshot and the
    // first output position; a final job walks down to position zero.
    typedef struct packed {
        logic [WIN_DEPTH-1:0][SAMPLE_W-1:0] win;
        logic [D_W-1:0]                     d_start;
        logic                               last;
    } sff_job_t;

endpackage

[sv/sff_front.sv]
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the sample window and fill count, and
// classifies each sample into a job for the back end. Depends on sff_pkg.
module sff_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  sff_pkg::sff_cfg_t cfg,
    input  logic              src_valid,
    output logic              src_stall,
    input  sff_pkg::sff_in_t  src_item,
    input  logic              q_full,
    output logic              q_push,
    output sff_pkg::sff_job_t q_job
);

    logic [sff_pkg::WIN_DEPTH-1:0][sff_pkg::SAMPLE_W-1:0] win_reg;
    logic [sff_pkg::WIN_DEPTH-1:0][sff_pkg::SAMPLE_W-1:0] win_next;
    logic [sff_pkg::WIN_DEPTH-1:0][sff_pkg::SAMPLE_W-1:0] win_shifted;
    logic [sff_pkg::D_W-1:0] filled_reg;
    logic [sff_pkg::D_W-1:0] filled_next;
    logic [sff_pkg::D_W-1:0] lag;
    logic                    accept;
    logic                    last;

    // Output lag for the current kernel shape.
    assign lag = sff_pkg::D_W'(int'(cfg.taps >> 1) * int'(cfg.channels));

    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign last      = src_item.final_req;

    // Newest sample enters at position zero.
    always_comb
    begin
        win_shifted[0] = src_item.sample;
        for (int i = 1; i < sff_pkg::WIN_DEPTH; i++)
        begin
            win_shifted[i] = win_reg[i-1];
        end
    end

    // Classify: an ordinary sample yields one output once the window holds
    // the lag; the final sample flushes everything still pending.
    always_comb
    begin
        q_push        = accept && (last || (filled_reg >= lag));
        q_job.win     = win_shifted;
        q_job.last    = last;
        q_job.d_start = lag;
        if (last && (filled_reg < lag))
        begin
            q_job.d_start = filled_reg;
        end
    end

    // Window and fill count, cleared after the final sample.
    always_comb
    begin
        win_next    = win_reg;
        filled_next = filled_reg;
        if (accept)
        begin
            if (last)
            begin
                win_next    = '0;
                filled_next = '0;
            end
            else
            begin
                win_next = win_shifted;
                if (int'(filled_reg) < sff_pkg::LAG_MAX)
                begin
                    filled_next = filled_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            filled_reg <= '0;
        end
        else
        begin
            win_reg    <= win_next;
            filled_reg <= filled_next;
        end
    end

    // Assertions.
    a_filled_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(filled_reg) <= sff_pkg::LAG_MAX)
        else $error("fill count exceeds the maximum lag");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (filled_reg == '0 && win_reg == '0))
        else $error("window not cleared after the final sample");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push)
        else $error("job pushed into a full queue");

endmodule

[sv/sff_queue.sv]
`timescale 1ns / 1ps
// Short job queue that decouples the front end from the back end.
// Depends on sff_pkg for the job type and depth.
module sff_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sff_pkg::sff_job_t push_job,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output sff_pkg::sff_job_t head
);

    sff_pkg::sff_job_t entry_reg [sff_pkg::QDEPTH];
    logic [sff_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sff_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [sff_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sff_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [sff_pkg::QCNT_W-1:0] count_reg;
    logic [sff_pkg::QCNT_W-1:0] count_next;

    assign full      = (count_reg == sff_pkg::QCNT_W'(sff_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == sff_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == sff_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Assertions.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (full && push) |-> pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

[sv/sff_back.sv]
`timescale 1ns / 1ps
// Back end: walks each job's output positions, multiplies the taps in one
// stage, sums and saturates into the output register. Depends on sff_pkg.
module sff_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  sff_pkg::sff_cfg_t cfg,
    input  logic              q_valid,
    input  sff_pkg::sff_job_t q_head,
    output logic              q_pop,
    output logic              res_valid,
    input  logic              res_stall,
    output sff_pkg::sff_out_t res_item
);

    // Per-tap window offsets, refreshed from the configuration every cycle.
    logic signed [sff_pkg::OFS_W-1:0] ofs_reg  [sff_pkg::MAX_TAPS];
    logic signed [sff_pkg::OFS_W-1:0] ofs_next [sff_pkg::MAX_TAPS];
    logic [sff_pkg::MAX_TAPS-1:0]     use_reg;
    logic [sff_pkg::MAX_TAPS-1:0]     use_next;

    // Position sequencer.
    logic                    busy_reg;
    logic                    busy_next;
    logic [sff_pkg::D_W-1:0] d_reg;
    logic [sff_pkg::D_W-1:0] d_next;
    logic [sff_pkg::D_W-1:0] cur_d;
    logic                    issue;
    logic                    issue_end;

    // Product stage.
    logic signed [sff_pkg::PROD_W-1:0] prod_reg  [sff_pkg::MAX_TAPS];
    logic signed [sff_pkg::PROD_W-1:0] prod_next [sff_pkg::MAX_TAPS];
    logic                              s1_valid_reg;
    logic                              s1_end_reg;
    logic                              s1_en;

    // Sum and output stage.
    logic signed [sff_pkg::SUM_W-1:0] sum;
    logic signed [sff_pkg::SUM_W-1:0] shifted;
    logic [sff_pkg::SAMPLE_W-1:0]     pixel;
    logic                             out_valid_reg;
    sff_pkg::sff_out_t                out_item_reg;
    logic                             out_load;

    // Tap offsets: tap f reads (taps/2 - f) * channels beyond the position.
    always_comb
    begin
        for (int f = 0; f < sff_pkg::MAX_TAPS; f++)
        begin
            ofs_next[f] = sff_pkg::OFS_W'((int'(cfg.taps >> 1) - f) * int'(cfg.channels));
            use_next[f] = (f < int'(cfg.taps));
        end
    end

    always_ff @(posedge clk)
    begin
        ofs_reg <= ofs_next;
        use_reg <= use_next;
    end

    // Pipeline enables, from the output back to the sequencer.
    assign out_load = s1_valid_reg && (!out_valid_reg || !res_stall);
    assign s1_en    = !s1_valid_reg || out_load;

    // Sequencer: an ordinary job issues once, a final job counts down to zero.
    always_comb
    begin
        cur_d     = busy_reg ? d_reg : q_head.d_start;
        issue     = q_valid && s1_en;
        issue_end = q_head.last && (cur_d == '0);
        q_pop     = issue && (!q_head.last || (cur_d == '0));
        busy_next = busy_reg;
        d_next    = d_reg;
        if (issue)
        begin
            busy_next = q_head.last && (cur_d != '0);
            d_next    = cur_d - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            d_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            d_reg    <= d_next;
        end
    end

    // Tap selection and multiply; taps outside the window contribute zero.
    always_comb
    begin
        logic signed [sff_pkg::KS_W-1:0] k;
        logic [sff_pkg::SAMPLE_W-1:0]    tap_byte;
        logic                            in_range;
        for (int f = 0; f < sff_pkg::MAX_TAPS; f++)
        begin
            k        = $signed(sff_pkg::KS_W'(cur_d)) + sff_pkg::KS_W'(ofs_reg[f]);
            in_range = !k[sff_pkg::KS_W-1] &&
                       (int'(k[sff_pkg::K_W-1:0]) < sff_pkg::WIN_DEPTH);
            tap_byte = (in_range && use_reg[f]) ? q_head.win[k[sff_pkg::K_W-1:0]] : '0;
            prod_next[f] = $signed({1'b0, tap_byte}) * $signed(cfg.coef[f]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            prod_reg   <= prod_next;
            s1_end_reg <= issue_end;
        end
    end

    // Sum of products, truncated toward zero and saturated to a byte.
    always_comb
    begin
        sum = '0;
        for (int f = 0; f < sff_pkg::MAX_TAPS; f++)
        begin
            sum = sum + sff_pkg::SUM_W'(prod_reg[f]);
        end
        shifted = sum >>> sff_pkg::FRAC_BITS;
        if (sum[sff_pkg::SUM_W-1] || (sum == '0))
        begin
            pixel = '0;
        end
        else if (shifted > sff_pkg::SUM_W'(sff_pkg::PIXEL_MAX))
        begin
            pixel = sff_pkg::SAMPLE_W'(sff_pkg::PIXEL_MAX);
        end
        else
        begin
            pixel = shifted[sff_pkg::SAMPLE_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg.pixel      <= pixel;
            out_item_reg.end_of_run <= s1_end_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_item  = out_item_reg;

    // Assertions.
    a_busy_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (q_valid && q_head.last))
        else $error("flush in progress without a final job at the queue head");

    a_flush_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !q_pop) |=> busy_reg)
        else $error("flush stopped before position zero");

    a_flush_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && issue && !q_pop) |=> (d_reg == $past(d_reg) - 1'b1))
        else $error("flush skipped a position");

    a_final_pops_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |-> (cur_d == '0))
        else $error("final job retired before its last output");

endmodule

[sv/strided_fir_filter.sv]
`timescale 1ns / 1ps
// Strided FIR filter top level: configuration registers, front end, job queue, back end.
// A sample that yields an output passes the job queue, the product and output registers.
// Throughput: one sample per cycle; a final sample yields up to LAG_MAX + 1 outputs,
// one per cycle while res_stall is low; the input stalls once the two-entry queue is full.
// Reset: window, fill count, queue and pipeline clear; registers take their reset values.
// Depends on sff_pkg, sff_front, sff_queue and sff_back.
module strided_fir_filter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    output logic                              src_stall,
    input  sff_pkg::sff_in_t                  src_item,
    output logic                              res_valid,
    input  logic                              res_stall,
    output sff_pkg::sff_out_t                 res_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sff_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [sff_pkg::COEF_W-1:0]        cfg_data
);

    logic [sff_pkg::CFG_W-1:0]  channel_count_reg;
    logic [sff_pkg::CFG_W-1:0]  channel_count_next;
    logic [sff_pkg::CFG_W-1:0]  tap_count_reg;
    logic [sff_pkg::CFG_W-1:0]  tap_count_next;
    logic [sff_pkg::COEF_W-1:0] coef_reg  [sff_pkg::COEF_REGS];
    logic [sff_pkg::COEF_W-1:0] coef_next [sff_pkg::COEF_REGS];
    logic [sff_pkg::COEF_IDX_W-1:0] coef_idx;
    sff_pkg::sff_cfg_t          cfg;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_valid;
    sff_pkg::sff_job_t q_job;
    sff_pkg::sff_job_t q_head;

    assign cfg_ready = 1'b1;
    assign coef_idx  = sff_pkg::COEF_IDX_W'(cfg_index - sff_pkg::REG_COEF_0);

    // Register write decode.
    always_comb
    begin
        channel_count_next = channel_count_reg;
        tap_count_next     = tap_count_reg;
        coef_next          = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (sff_pkg::reg_idx_t'(cfg_index)) inside
                sff_pkg::REG_CHANNEL_COUNT:
                begin
                    channel_count_next = cfg_data[sff_pkg::CFG_W-1:0];
                end
                sff_pkg::REG_TAP_COUNT:
                begin
                    tap_count_next = cfg_data[sff_pkg::CFG_W-1:0];
                end
                [sff_pkg::REG_COEF_0:sff_pkg::REG_COEF_4]:
                begin
                    coef_next[coef_idx] = cfg_data;
                end
                default:
                begin
                    channel_count_next = channel_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= sff_pkg::CFG_W'(1);
            tap_count_reg     <= sff_pkg::CFG_W'(3);
            for (int i = 0; i < sff_pkg::COEF_REGS; i++)
            begin
                coef_reg[i] <= (i == 1) ? sff_pkg::COEF_W'(4096) : '0;
            end
        end
        else
        begin
            channel_count_reg <= channel_count_next;
            tap_count_reg     <= tap_count_next;
            coef_reg          <= coef_next;
        end
    end

    // Clamp the counts into their usable ranges; taps without a register get zero.
    always_comb
    begin
        if (channel_count_reg == '0)
        begin
            cfg.channels = sff_pkg::CH_W'(1);
        end
        else if (int'(channel_count_reg) > sff_pkg::MAX_CHANNELS)
        begin
            cfg.channels = sff_pkg::CH_W'(sff_pkg::MAX_CHANNELS);
        end
        else
        begin
            cfg.channels = sff_pkg::CH_W'(channel_count_reg);
        end
        if (tap_count_reg == '0)
        begin
            cfg.taps = sff_pkg::TAP_W'(1);
        end
        else if (int'(tap_count_reg) > sff_pkg::MAX_TAPS)
        begin
            cfg.taps = sff_pkg::TAP_W'(sff_pkg::MAX_TAPS);
        end
        else
        begin
            cfg.taps = sff_pkg::TAP_W'(tap_count_reg);
        end
        for (int f = 0; f < sff_pkg::MAX_TAPS; f++)
        begin
            cfg.coef[f] = (f < sff_pkg::COEF_REGS) ? coef_reg[f] : '0;
        end
    end

    sff_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    sff_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sff_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

[sim/sff_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the strided FIR filter: follows register writes, predicts every filtered
// pixel from the accepted sample requests and compares it with the result requests.
// Depends on sff_pkg for the payload types, register codes and geometry.
module sff_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          src_valid,
    input  logic                          src_stall,
    input  sff_pkg::sff_in_t              src_item,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  sff_pkg::sff_out_t             res_item,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sff_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [sff_pkg::COEF_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            outstanding,
    output int                            pixels_checked,
    output int                            runs_closed
);

    // Shadow copy of the registers and of the sample history.
    logic [sff_pkg::CFG_W-1:0]          chan_reg;
    logic [sff_pkg::CFG_W-1:0]          taps_reg;
    logic signed [sff_pkg::COEF_W-1:0]  coef_reg [0:sff_pkg::COEF_REGS-1];
    logic [sff_pkg::SAMPLE_W-1:0]       sample_hist [0:sff_pkg::WIN_DEPTH-1];
    int                                 seen_count;
    sff_pkg::sff_out_t                  expected_pixels [$];

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic clear_history();
        for (int k = 0; k < sff_pkg::WIN_DEPTH; k++)
            sample_hist[k] = '0;
        seen_count = 0;
    endtask

    task automatic reset_shadow();
        chan_reg = sff_pkg::CFG_W'(1);
        taps_reg = sff_pkg::CFG_W'(3);
        for (int i = 0; i < sff_pkg::COEF_REGS; i++)
            coef_reg[i] = '0;
        coef_reg[1] = sff_pkg::COEF_W'(4096);
        clear_history();
        expected_pixels.delete();
    endtask

    task automatic apply_write(input logic [sff_pkg::REG_IDX_W-1:0] idx,
                               input logic [sff_pkg::COEF_W-1:0] value);
        case (idx) inside
            sff_pkg::REG_CHANNEL_COUNT: chan_reg = value[sff_pkg::CFG_W-1:0];
            sff_pkg::REG_TAP_COUNT:     taps_reg = value[sff_pkg::CFG_W-1:0];
            [sff_pkg::REG_COEF_0:sff_pkg::REG_COEF_4]:
                coef_reg[idx - sff_pkg::REG_COEF_0] = value;
            default: ;
        endcase
    endtask

    // Kernel sum for the position d samples behind the newest one, truncated and clipped.
    function automatic logic [sff_pkg::SAMPLE_W-1:0] filtered_pixel(int d, int ch, int taps);
        int     half;
        int     k;
        longint acc;
        half = taps / 2;
        acc  = 0;
        for (int f = 0; f < taps; f++)
        begin
            k = d + (half - f) * ch;
            if (k >= 0 && k < sff_pkg::WIN_DEPTH && f < sff_pkg::COEF_REGS)
                acc += longint'(sample_hist[k]) * longint'(coef_reg[f]);
        end
        if (acc <= 0)
            return '0;
        acc = acc >>> sff_pkg::FRAC_BITS;
        if (acc > sff_pkg::PIXEL_MAX)
            return sff_pkg::SAMPLE_W'(sff_pkg::PIXEL_MAX);
        return sff_pkg::SAMPLE_W'(acc);
    endfunction

    // Shifts one sample in and queues the pixels it releases.
    task automatic absorb_sample(input sff_pkg::sff_in_t req);
        int                ch;
        int                taps;
        int                lag;
        int                d;
        sff_pkg::sff_out_t want;
        ch   = (chan_reg == 0) ? 1 : ((chan_reg > sff_pkg::MAX_CHANNELS) ?
                                      sff_pkg::MAX_CHANNELS : chan_reg);
        taps = (taps_reg == 0) ? 1 : ((taps_reg > sff_pkg::MAX_TAPS) ?
                                      sff_pkg::MAX_TAPS : taps_reg);
        lag  = (taps / 2) * ch;
        for (int k = sff_pkg::WIN_DEPTH - 1; k > 0; k--)
            sample_hist[k] = sample_hist[k-1];
        sample_hist[0] = req.sample;
        if (!req.final_req)
        begin
            if (seen_count >= lag)
            begin
                want.pixel      = filtered_pixel(lag, ch, taps);
                want.end_of_run = 1'b0;
                expected_pixels.push_back(want);
            end
            if (seen_count < sff_pkg::LAG_MAX)
                seen_count++;
        end
        else
        begin
            // The closing sample flushes every pending position down to the newest.
            d = (seen_count < lag) ? seen_count : lag;
            while (d >= 0)
            begin
                want.pixel      = filtered_pixel(d, ch, taps);
                want.end_of_run = (d == 0);
                expected_pixels.push_back(want);
                d--;
            end
            clear_history();
            runs_closed++;
        end
    endtask

    task automatic check_pixel(input sff_pkg::sff_out_t got);
        sff_pkg::sff_out_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("unexpected pixel %0d end_of_run %0b",
                                      got.pixel, got.end_of_run));
            return;
        end
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (got.pixel !== want.pixel)
            report_mismatch($sformatf("pixel %0d, expected %0d (output %0d)",
                                      got.pixel, want.pixel, pixels_checked));
        if (got.end_of_run !== want.end_of_run)
            report_mismatch($sformatf("end_of_run %0b, expected %0b (output %0d)",
                                      got.end_of_run, want.end_of_run, pixels_checked));
    endtask

    // Results are compared before the same edge's sample is absorbed, since the
    // block cannot answer a sample in the cycle it takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
            reset_shadow();
        else
        begin
            if (res_valid && !res_stall)
                check_pixel(res_item);
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (src_valid && !src_stall)
                absorb_sample(src_item);
        end
        outstanding = expected_pixels.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Top of the strided FIR filter testbench: clock, reset, stimulus and verdict.
// Depends on sff_pkg, strided_fir_filter and the sff_checker scoreboard.
module tb;

    localparam int CLK_HALF        = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DIRECTED_ITEMS  = 22;
    localparam int RANDOM_ITEMS    = 400;
    localparam logic [sff_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd7;   // not mapped to any register

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          src_valid = 1'b0;
    logic                          src_stall;
    sff_pkg::sff_in_t              src_item  = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    sff_pkg::sff_out_t             res_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [sff_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [sff_pkg::COEF_W-1:0]    cfg_data  = '0;

    int  fail_count;
    int  outstanding;
    int  pixels_checked;
    int  runs_closed;
    int  samples_sent = 0;
    int  writes_done  = 0;
    int  cycle_count  = 0;
    int  hold_left    = 0;
    bit  gaps_on      = 1'b1;
    bit  hold_off_req = 1'b0;
    bit  hold_taken   = 1'b0;

    always #(CLK_HALF) clk = ~clk;

    strided_fir_filter u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sff_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .src_valid      (src_valid),
        .src_stall      (src_stall),
        .src_item       (src_item),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_item       (res_item),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked),
        .runs_closed    (runs_closed)
    );

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d outputs outstanding.",
                     CYCLE_LIMIT, outstanding);
            $display("strided_fir_filter verification failed");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off counted here.
    always @(negedge clk)
    begin
        if (hold_off_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= gaps_on && ($urandom_range(99) < 17);
    end

    // Offers one sample request and returns at the edge that takes it; valid stays
    // high so that back-to-back requests need no bubble.
    task automatic push_sample(input logic [sff_pkg::SAMPLE_W-1:0] value, input logic last);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 17)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_item  <= '{sample: value, final_req: last};
        src_valid <= 1'b1;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        samples_sent++;
    endtask

    // Stops sending and waits until every predicted pixel has come out.
    task automatic drain_results();
        @(negedge clk);
        src_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [sff_pkg::REG_IDX_W-1:0] idx,
                             input logic [sff_pkg::COEF_W-1:0] value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    task automatic write_all_coefs(input logic [sff_pkg::COEF_W-1:0] value);
        for (int i = 0; i < sff_pkg::COEF_REGS; i++)
            write_reg(sff_pkg::REG_IDX_W'(sff_pkg::REG_COEF_0 + i), value);
    endtask

    function automatic logic [sff_pkg::COEF_W-1:0] random_coef();
        case ($urandom_range(5))
            0:       return sff_pkg::COEF_W'($urandom);
            1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: return sff_pkg::COEF_W'($urandom_range(6144) - 1024);
        endcase
    endfunction

    function automatic logic [sff_pkg::SAMPLE_W-1:0] random_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return sff_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Counts carry random upper bits; only the low bits reach the registers.
    task automatic load_random_setting();
        write_reg(sff_pkg::REG_CHANNEL_COUNT, sff_pkg::COEF_W'($urandom));
        write_reg(sff_pkg::REG_TAP_COUNT, sff_pkg::COEF_W'($urandom));
        for (int i = 0; i < sff_pkg::COEF_REGS; i++)
            write_reg(sff_pkg::REG_IDX_W'(sff_pkg::REG_COEF_0 + i), random_coef());
        if ($urandom_range(3) == 0)
            write_reg(REG_SPARE, sff_pkg::COEF_W'($urandom));
    endtask

    task automatic send_buffer(input int len, input bit close);
        for (int i = 0; i < len; i++)
            push_sample(random_sample(), close && (i == len - 1));
    endtask

    initial
    begin
        int run_len;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: identity kernel over three taps, extreme samples,
        // then a buffer of one sample.
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd128, 1'b0);
        push_sample(8'd1, 1'b0);
        push_sample(8'd200, 1'b1);
        push_sample(8'd77, 1'b1);
        drain_results();

        // Widest geometry with the largest coefficients; the buffer is shorter than the lag.
        write_reg(sff_pkg::REG_CHANNEL_COUNT, 16'd4);
        write_reg(sff_pkg::REG_TAP_COUNT, 16'd5);
        write_all_coefs(16'h7FFF);
        push_sample(8'd255, 1'b0);
        push_sample(8'd1, 1'b0);
        push_sample(8'd128, 1'b1);
        drain_results();

        // Most negative coefficients drive every sum below zero.
        write_all_coefs(16'h8000);
        repeat (3) push_sample(8'd255, 1'b0);
        push_sample(8'd255, 1'b1);
        drain_results();

        // Zero counts behave as one; a write to the unmapped index changes nothing.
        write_reg(sff_pkg::REG_CHANNEL_COUNT, 16'd0);
        write_reg(sff_pkg::REG_TAP_COUNT, 16'd0);
        write_reg(sff_pkg::REG_COEF_0, 16'h1000);
        write_reg(REG_SPARE, 16'hFFFF);
        push_sample(8'd9, 1'b0);
        push_sample(8'd250, 1'b0);
        push_sample(8'd3, 1'b1);
        drain_results();

        // Counts above the maximum clamp to it.
        write_reg(sff_pkg::REG_CHANNEL_COUNT, 16'hFFFF);
        write_reg(sff_pkg::REG_TAP_COUNT, 16'hFFFE);
        write_all_coefs(16'h0666);
        push_sample(8'd10, 1'b0);
        push_sample(8'd250, 1'b0);
        push_sample(8'd40, 1'b0);
        push_sample(8'd0, 1'b0);
        push_sample(8'd255, 1'b0);
        push_sample(8'd90, 1'b1);
        drain_results();

        // Random phases; an open buffer may carry over into the next setting.
        for (int phase = 0; samples_sent < DIRECTED_ITEMS + RANDOM_ITEMS; phase++)
        begin
            gaps_on = (phase != 2);
            load_random_setting();
            if (phase == 1)
            begin
                // Long hold-off on the result side fills the block and stalls the input.
                write_reg(sff_pkg::REG_CHANNEL_COUNT, 16'd4);
                write_reg(sff_pkg::REG_TAP_COUNT, 16'd5);
                hold_off_req = 1'b1;
                send_buffer(40, 1'b1);
            end
            if (phase == 2)
            begin
                // One long buffer with no idling on either side.
                send_buffer(60, 1'b1);
            end
            repeat ($urandom_range(1, 3))
            begin
                run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 40)
                                                   : $urandom_range(1, 20);
                send_buffer(run_len, 1'b1);
            end
            if ($urandom_range(2) == 0)
                send_buffer($urandom_range(1, 12), 1'b0);
            drain_results();
        end
        gaps_on = 1'b1;
        repeat (20) @(negedge clk);

        $display("Sent %0d samples in %0d closed buffers across %0d register writes,",
                 samples_sent, runs_closed, writes_done);
        $display("with stalls on both sides; %0d pixels compared, %0d mismatches.",
                 pixels_checked, fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("strided_fir_filter verification clean");
        else
            $display("strided_fir_filter verification failed");
        $finish;
    end

endmodule

[files.f]
sv/sff_pkg.sv
sv/sff_front.sv
sv/sff_queue.sv
sv/sff_back.sv
sv/strided_fir_filter.sv
sim/sff_checker.sv
sim/tb.sv
